// ----- rtl/ipcm_pkg.sv -----
// package: shared constants, types and conversion helpers for the pcm converter
`timescale 1ns / 1ps

package ipcm_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int SAMPLE_W     = 16;
  localparam int SUM_W        = 20;
  localparam int MAG_W        = SUM_W - 1;
  localparam int DIV_STEPS    = MAG_W;
  localparam int STEP_W       = $clog2(DIV_STEPS);
  localparam int CHAN_W       = 4;

  localparam logic [2:0] REG_SAMPLE_BYTES   = 3'd0;
  localparam logic [2:0] REG_VALID_BITS     = 3'd1;
  localparam logic [2:0] REG_CHANNEL_COUNT  = 3'd2;
  localparam logic [2:0] REG_DOWNMIX_ENABLE = 3'd3;

  localparam logic [2:0] BYTES_8  = 3'd1;
  localparam logic [2:0] BYTES_16 = 3'd2;
  localparam logic [2:0] BYTES_24 = 3'd3;
  localparam logic [2:0] BYTES_32 = 3'd4;

  typedef struct packed {
    logic              start;
    logic              neg;
    logic [MAG_W-1:0]  mag;
    logic [CHAN_W-1:0] divisor;
  } div_req_t;

  // top 16 bits of a 16/24/32-bit sample, with bits under the valid-bit count cleared; 8-bit is offset and scaled
  function automatic logic signed [SAMPLE_W-1:0] convert_sample(
      input logic [31:0] raw, input logic [2:0] sb, input logic [5:0] vb);
    logic [15:0] top;
    logic [4:0]  keep;
    logic [15:0] mask;
    keep = (vb >= 6'd16) ? 5'd16 : vb[4:0];
    mask = ~(16'hFFFF >> keep);
    unique case (sb)
      BYTES_16: top = raw[15:0];
      BYTES_24: top = raw[23:8];
      BYTES_32: top = raw[31:16];
      default:  top = raw[15:0];
    endcase
    if (sb == BYTES_8) begin
      // unsigned 8-bit: remove the 0x80 offset and scale by 0x100
      convert_sample = {~raw[7], raw[6:0], 8'h00};
    end else begin
      convert_sample = top & mask;
    end
  endfunction

  function automatic logic [CHAN_W-1:0] effective_channels(input logic [CHAN_W-1:0] cc);
    logic [CHAN_W-1:0] n;
    n = cc;
    if (n == '0) begin
      n = CHAN_W'(1);
    end
    if (n > CHAN_W'(MAX_CHANNELS)) begin
      n = CHAN_W'(MAX_CHANNELS);
    end
    effective_channels = n;
  endfunction

endpackage

// ----- rtl/ipcm_div.sv -----
// serial restoring divider: frame sum magnitude by channel count, one bit a cycle
`timescale 1ns / 1ps

module ipcm_div (
  input  logic                       clk,
  input  logic                       rst,
  input  ipcm_pkg::div_req_t         req,
  output logic                       done,
  output logic signed [ipcm_pkg::SAMPLE_W-1:0] quotient
);
  import ipcm_pkg::*;

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [CHAN_W-1:0] rem;
  logic [MAG_W-1:0]  quo;
  logic [CHAN_W-1:0] divisor;
  logic              neg;
  logic [CHAN_W:0]   trial;
  logic              fits;
  logic [CHAN_W:0]   trial_sub;
  logic              last_step;

  assign trial     = {rem, quo[MAG_W-1]};
  assign fits      = trial >= {1'b0, divisor};
  assign trial_sub = trial - {1'b0, divisor};
  assign last_step = step == STEP_W'(DIV_STEPS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && last_step;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        busy <= !last_step;
        step <= step + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.mag;
      rem     <= '0;
      divisor <= req.divisor;
      neg     <= req.neg;
    end else if (busy) begin
      rem <= fits ? trial_sub[CHAN_W-1:0] : trial[CHAN_W-1:0];
      quo <= {quo[MAG_W-2:0], fits};
    end
  end

  // truncation toward zero: divide the magnitude, then restore the sign
  assign quotient = neg ? -$signed(quo[SAMPLE_W-1:0]) : $signed(quo[SAMPLE_W-1:0]);

endmodule

// ----- rtl/integer_pcm_to_int16_downmix_core.sv -----
// top level: integer pcm to signed 16-bit converter with optional frame downmix
`timescale 1ns / 1ps

// Takes one interleaved channel sample per transfer on the input channel
// (in_valid / in_stall, raw_sample) and returns signed 16-bit samples on the
// output channel (out_valid / out_stall, sample_out). 8-bit input is unsigned
// with a 0x80 offset; 16-, 24- and 32-bit input is signed and masked to the
// valid-bit count before the top 16 bits are kept.
// Without downmix (or with one channel) every sample gives one registered result,
// and a new sample is taken every cycle while no result waits on a stalled output.
// With downmix, samples of a frame are summed as they are taken; the last
// sample of a frame starts the serial divider, and the frame average goes to
// the output register once the divider is done. The input is stalled while
// the divider runs.
// A finished result sits in the output register; if the receiver stalls and
// another result is done, that one waits in a holding register and the input
// is stalled until the output register frees up.
// Configuration writes (cfg_write, cfg_index, cfg_data) to indices 0..3 take effect
// at once and drop any partial frame. Sample widths other than 1..4 bytes give
// no result. Reset restores 16-bit stereo without downmix and an empty frame.
module integer_pcm_to_int16_downmix_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] raw_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [ipcm_pkg::SAMPLE_W-1:0] sample_out,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [5:0]  cfg_data
);
  import ipcm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t state, state_next;

  logic [2:0]        sample_bytes;
  logic [5:0]        valid_bits;
  logic [CHAN_W-1:0] channel_count;
  logic              downmix_enable;

  logic signed [SUM_W-1:0]    frame_sum, frame_sum_next;
  logic [2:0]                 channel_position, channel_position_next;
  logic signed [SAMPLE_W-1:0] hold_val, hold_val_next;

  logic signed [SAMPLE_W-1:0] conv;
  logic [CHAN_W-1:0]          n_eff;
  logic                       width_ok;
  logic                       dm_active;
  logic signed [SUM_W-1:0]    sum_add;
  logic signed [SUM_W-1:0]    sum_neg;
  logic [CHAN_W-1:0]          pos_inc;
  logic                       in_xfer;
  logic                       out_free;
  logic                       load_out;
  logic signed [SAMPLE_W-1:0] load_val;
  logic                       cfg_hit;

  div_req_t                   div_req;
  logic                       div_done;
  logic signed [SAMPLE_W-1:0] div_q;

  ipcm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_stall  = state != ST_IDLE;
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign conv      = convert_sample(raw_sample, sample_bytes, valid_bits);
  assign n_eff     = effective_channels(channel_count);
  assign width_ok  = (sample_bytes == BYTES_8) || (sample_bytes == BYTES_16) ||
                     (sample_bytes == BYTES_24) || (sample_bytes == BYTES_32);
  assign dm_active = downmix_enable && (n_eff != CHAN_W'(1));
  assign sum_add   = frame_sum + SUM_W'(conv);
  assign sum_neg   = -sum_add;
  assign pos_inc   = {1'b0, channel_position} + CHAN_W'(1);
  assign cfg_hit   = cfg_write && (cfg_index <= REG_DOWNMIX_ENABLE);

  always_comb begin
    state_next            = state;
    frame_sum_next        = frame_sum;
    channel_position_next = channel_position;
    hold_val_next         = hold_val;
    load_out              = 1'b0;
    load_val              = conv;
    div_req               = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer && width_ok) begin
          if (!dm_active) begin
            if (out_free) begin
              load_out = 1'b1;
            end else begin
              hold_val_next = conv;
              state_next    = ST_HOLD;
            end
          end else if (pos_inc < n_eff) begin
            frame_sum_next        = sum_add;
            channel_position_next = pos_inc[2:0];
          end else begin
            // frame complete: hand the sum to the divider
            div_req.start         = 1'b1;
            div_req.neg           = sum_add[SUM_W-1];
            div_req.mag           = sum_add[SUM_W-1] ? sum_neg[MAG_W-1:0] :
                                                       sum_add[MAG_W-1:0];
            div_req.divisor       = n_eff;
            frame_sum_next        = '0;
            channel_position_next = '0;
            state_next            = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (out_free) begin
            load_out   = 1'b1;
            load_val   = div_q;
            state_next = ST_IDLE;
          end else begin
            hold_val_next = div_q;
            state_next    = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          load_out   = 1'b1;
          load_val   = hold_val;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    // any write to one of the four registers drops a partial frame
    if (cfg_hit) begin
      frame_sum_next        = '0;
      channel_position_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      sample_bytes     <= BYTES_16;
      valid_bits       <= 6'd16;
      channel_count    <= CHAN_W'(2);
      downmix_enable   <= 1'b0;
      frame_sum        <= '0;
      channel_position <= '0;
      out_valid        <= 1'b0;
    end else begin
      state            <= state_next;
      frame_sum        <= frame_sum_next;
      channel_position <= channel_position_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          REG_SAMPLE_BYTES:   sample_bytes   <= cfg_data[2:0];
          REG_VALID_BITS:     valid_bits     <= cfg_data;
          REG_CHANNEL_COUNT:  channel_count  <= cfg_data[CHAN_W-1:0];
          REG_DOWNMIX_ENABLE: downmix_enable <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    hold_val <= hold_val_next;
    if (load_out) begin
      sample_out <= load_val;
    end
  end

  // a partial frame never reaches the channel count
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> ({1'b0, channel_position} < n_eff))
    else $error("frame position reached channel count while idle");

  // divider finishes only while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside the divide state");

  // a held result implies the output register is still occupied
  a_hold_blocked: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD) |-> out_valid)
    else $error("result held while output register is empty");

  // a pass-through sample leaves the output register valid on the next cycle
  a_pass_result: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && width_ok && !dm_active && !cfg_write) |=> out_valid)
    else $error("pass-through sample produced no result");

endmodule

// ----- test/tb.sv -----
// testbench for the integer pcm to int16 converter with frame downmix
`timescale 1ns / 1ps

module tb;
  import ipcm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  // the serial divider and then the output register must finish before the core is quiet
  localparam int SETTLE_CYCLES  = 30;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PHASE_ITEMS    = 130;
  localparam int NOISE_ITEMS    = 20;
  localparam int NUM_PHASES     = 14;
  localparam int MAX_REPORTS    = 30;

  localparam logic [2:0] REG_UNUSED = 3'd5;
  localparam logic [2:0] BYTES_NONE = 3'd0;
  localparam logic [2:0] BYTES_BAD  = 3'd5;
  localparam logic [2:0] BYTES_TOP  = 3'd7;

  typedef struct {
    bit                 is_cfg;
    logic [2:0]         idx;
    logic [5:0]         val;
    logic [31:0]        raw;
    bit                 typed;
    logic signed [15:0] want;
  } dir_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] raw_sample = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [5:0]  cfg_data = '0;

  // predictor copy of the registers and the frame accumulator
  logic [2:0]  pred_bytes;
  logic [5:0]  pred_valid_bits;
  logic [3:0]  pred_chans;
  logic        pred_mix;
  int          frame_acc;
  int unsigned frame_fill;

  logic signed [15:0] pending_out[$];
  dir_row_t           dir_rows[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int fail_count = 0;
  int samples_sent = 0;
  int results_checked = 0;
  int reg_writes = 0;
  int idle_cycles = 0;
  logic signed [15:0] head_want;

  integer_pcm_to_int16_downmix_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .raw_sample (raw_sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("MISMATCH at %0t: %s", $realtime, what);
    end
  endtask

  // converts one sample and, when downmixing, folds it into the frame; returns 1 when a result is due
  function automatic bit predict_sample(input logic [31:0] raw,
                                        output logic signed [15:0] res);
    int unsigned width;
    int unsigned vb;
    int unsigned nch;
    logic [63:0] keep;
    logic [63:0] kept;
    logic signed [15:0] top;
    int conv;
    res = '0;
    if (pred_bytes < BYTES_8 || pred_bytes > BYTES_32) begin
      return 1'b0;
    end
    width = 8 * pred_bytes;
    if (pred_bytes == BYTES_8) begin
      conv = (int'(raw[7:0]) - 128) * 256;
    end else begin
      vb = (pred_valid_bits > width) ? width : 32'(pred_valid_bits);
      keep = ((64'd1 << width) - 64'd1) & ~((64'd1 << (width - vb)) - 64'd1);
      kept = {32'd0, raw} & keep;
      top = 16'(kept >> (width - 16));
      conv = int'(top);
    end
    if (pred_chans == 4'd0) begin
      nch = 1;
    end else if (pred_chans > MAX_CHANNELS) begin
      nch = MAX_CHANNELS;
    end else begin
      nch = 32'(pred_chans);
    end
    if (!pred_mix || nch == 1) begin
      res = 16'(conv);
      return 1'b1;
    end
    frame_acc += conv;
    frame_fill++;
    if (frame_fill < nch) begin
      return 1'b0;
    end
    res = 16'(frame_acc / int'(nch));
    frame_acc = 0;
    frame_fill = 0;
    return 1'b1;
  endfunction

  function automatic logic [31:0] rand_raw();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h1 << ($urandom_range(1, 4) * 8 - 1);
      3: return ~(32'h1 << ($urandom_range(1, 4) * 8 - 1));
      default: return $urandom();
    endcase
  endfunction

  // register writes wait for the core to go quiet
  task automatic write_reg(input logic [2:0] idx, input logic [5:0] val);
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    reg_writes++;
    case (idx)
      REG_SAMPLE_BYTES:   pred_bytes = val[2:0];
      REG_VALID_BITS:     pred_valid_bits = val;
      REG_CHANNEL_COUNT:  pred_chans = val[3:0];
      REG_DOWNMIX_ENABLE: pred_mix = val[0];
      default: ;
    endcase
    // a write to a real register drops the partial frame
    if (idx <= REG_DOWNMIX_ENABLE) begin
      frame_acc = 0;
      frame_fill = 0;
    end
    cfg_write <= 1'b0;
  endtask

  task automatic send_sample(input logic [31:0] v, input bit typed,
                             input logic signed [15:0] want);
    logic signed [15:0] res;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    raw_sample <= v;
    do @(posedge clk); while (in_stall);
    samples_sent++;
    if (predict_sample(v, res)) begin
      pending_out.push_back(typed ? want : res);
    end
  endtask

  task automatic add_cfg(input logic [2:0] idx, input logic [5:0] val);
    dir_rows.push_back('{1'b1, idx, val, 32'd0, 1'b0, 16'sd0});
  endtask

  task automatic add_smp(input logic [31:0] raw, input bit typed,
                         input logic signed [15:0] want);
    dir_rows.push_back('{1'b0, 3'd0, 6'd0, raw, typed, want});
  endtask

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_out.size() == 0) begin
        report_mismatch($sformatf("sample_out %0d with nothing expected", sample_out));
      end else begin
        head_want = pending_out.pop_front();
        results_checked++;
        if (sample_out !== head_want) begin
          report_mismatch($sformatf("sample_out %0d, expected %0d", sample_out, head_want));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int ph_bytes[NUM_PHASES];
    int ph_valid[NUM_PHASES];
    int ph_chans[NUM_PHASES];
    int ph_mix[NUM_PHASES];
    int count;
    dir_row_t row;

    pred_bytes = BYTES_16;
    pred_valid_bits = 6'd16;
    pred_chans = 4'd2;
    pred_mix = 1'b0;
    frame_acc = 0;
    frame_fill = 0;

    // reset state: 16-bit stereo, no downmix
    add_smp(32'h0000_7FFF, 1, 16'sd32767);
    add_smp(32'hFFFF_8000, 1, -16'sd32768);
    add_cfg(REG_SAMPLE_BYTES, 6'(BYTES_8));
    add_smp(32'h0000_0000, 1, -16'sd32768);
    add_smp(32'hFFFF_FFFF, 1, 16'sd32512);
    add_cfg(REG_SAMPLE_BYTES, 6'(BYTES_24));
    add_smp(32'h007F_FFFF, 1, 16'sd32767);
    add_smp(32'hFF80_0000, 1, -16'sd32768);
    add_cfg(REG_SAMPLE_BYTES, 6'(BYTES_32));
    add_smp(32'h8000_0000, 1, -16'sd32768);
    add_smp(32'h7FFF_FFFF, 1, 16'sd32767);
    // no valid bits masks everything
    add_cfg(REG_VALID_BITS, 6'd0);
    add_smp(32'hFFFF_FFFF, 1, 16'sd0);
    add_cfg(REG_VALID_BITS, 6'd63);
    add_smp(32'h1234_5678, 1, 16'sh1234);
    add_cfg(REG_VALID_BITS, 6'd4);
    add_smp(32'hFFFF_FFFF, 1, -16'sd4096);
    // unsupported widths give nothing
    add_cfg(REG_SAMPLE_BYTES, 6'(BYTES_NONE));
    add_smp(32'h0000_1234, 0, 16'sd0);
    add_cfg(REG_SAMPLE_BYTES, 6'(BYTES_TOP));
    add_smp(32'hFFFF_FFFF, 0, 16'sd0);
    add_cfg(REG_SAMPLE_BYTES, 6'(BYTES_16));
    add_cfg(REG_VALID_BITS, 6'd16);
    add_cfg(REG_DOWNMIX_ENABLE, 6'd1);
    add_smp(32'h0000_8000, 0, 16'sd0);
    add_smp(32'h0000_8000, 1, -16'sd32768);
    // write to an unused index keeps the partial frame
    add_smp(32'h0000_7FFF, 0, 16'sd0);
    add_cfg(REG_UNUSED, 6'd63);
    add_smp(32'h0000_0001, 0, 16'sd0);
    // a real write drops it; average of odd sum truncates toward zero
    add_smp(32'h0000_7FFF, 0, 16'sd0);
    add_cfg(REG_DOWNMIX_ENABLE, 6'd1);
    add_smp(32'h0000_8000, 0, 16'sd0);
    add_smp(32'h0000_0001, 0, 16'sd0);
    // zero channels acts as mono, so downmix passes through
    add_cfg(REG_CHANNEL_COUNT, 6'd0);
    add_smp(32'h0000_8001, 1, -16'sd32767);

    ph_bytes = '{2, 1, 3, 4, 4, 3, 2, 1, 4, 2, 5, 0, 0, 0};
    ph_valid = '{16, 8, 24, 32, 20, 0, 63, 5, 1, 9, 16, 0, 0, 0};
    ph_chans = '{2, 1, 6, 8, 15, 3, 0, 1, 5, 7, 2, 0, 0, 0};
    ph_mix   = '{1, 0, 1, 1, 1, 1, 1, 1, 1, 0, 1, 0, 0, 0};

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_cfg) begin
        write_reg(row.idx, row.val);
      end else begin
        send_sample(row.raw, row.typed, row.want);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph >= 11) begin
        ph_bytes[ph] = $urandom_range(1, 4);
        ph_valid[ph] = $urandom_range(0, 63);
        ph_chans[ph] = $urandom_range(0, 15);
        ph_mix[ph] = $urandom_range(0, 1);
      end
      write_reg(REG_SAMPLE_BYTES, 6'(ph_bytes[ph]));
      write_reg(REG_VALID_BITS, 6'(ph_valid[ph]));
      write_reg(REG_CHANNEL_COUNT, 6'(ph_chans[ph]));
      write_reg(REG_DOWNMIX_ENABLE, 6'(ph_mix[ph]));
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 71; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 71; end
        default: begin send_idle_pct = 13; stall_pct = 13; end
      endcase
      count = (ph_bytes[ph] == BYTES_BAD) ? NOISE_ITEMS : PHASE_ITEMS;
      for (int k = 0; k < count; k++) begin
        send_sample(rand_raw(), 0, 16'sd0);
      end
    end

    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d samples, checked %0d results, %0d register writes", samples_sent,
             results_checked, reg_writes);
    $display("covered 8/16/24/32-bit widths, bad widths, masking, downmix up to 8 channels");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ipcm_pkg.sv
rtl/ipcm_div.sv
rtl/integer_pcm_to_int16_downmix_core.sv
test/tb.sv
